/* hw/rtl/pdds_pkg.sv */
package pdds_pkg;

    // field and register widths
    localparam int ERR_W     = 16;
    localparam int DT_W      = 16;
    localparam int GAIN_W    = 24;
    localparam int LIM_W     = 31;
    localparam int SPD_W     = 16;
    localparam int OLIM_W    = 15;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    // datapath widths
    localparam int INTEG_W   = 32;
    localparam int ISUM_W    = INTEG_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int Q_W       = DIV_W + 1;
    localparam int MUL_A_W   = 24;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 58;
    localparam int CTL_SH    = 20;
    localparam int CTL_W     = 38;
    localparam int SAT_W     = 40;
    localparam int SHP_W     = 34;
    localparam int SLEW_W    = SPD_W + 2;

    // magnitude shaping constants
    localparam logic [15:0]        DEAD_ZONE = 16'd64;
    localparam logic [15:0]        SCALE_A   = 16'd256;
    localparam logic signed [15:0] OFFSET_B  = 16'sd0;

    // register reset values
    localparam logic signed [GAIN_W-1:0] RST_PROP_GAIN  = 24'sd65536;
    localparam logic signed [GAIN_W-1:0] RST_INTEG_GAIN = 24'sd0;
    localparam logic signed [GAIN_W-1:0] RST_DERIV_GAIN = 24'sd0;
    localparam logic [LIM_W-1:0]         RST_INTEG_LIM  = 31'd268435456;
    localparam logic signed [SPD_W-1:0]  RST_BASE_SPEED = 16'sd256;
    localparam logic signed [SPD_W-1:0]  RST_SPEED_CAP  = 16'sd1024;
    localparam logic [OLIM_W-1:0]        RST_OUT_LIMIT  = 15'd1024;
    localparam logic [OLIM_W-1:0]        RST_SLEW_LIMIT = 15'd64;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_INTEG_LIM  = 3'd3,
        CFG_BASE_SPEED = 3'd4,
        CFG_SPEED_CAP  = 3'd5,
        CFG_OUT_LIMIT  = 3'd6,
        CFG_SLEW_LIMIT = 3'd7
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_INT_MUL,
        S_INT_ADD,
        S_INT_CLAMP,
        S_KP_MUL,
        S_KP_ADD,
        S_KIL_MUL,
        S_KIL_ADD,
        S_KIH_MUL,
        S_KIH_ADD,
        S_DIV_WAIT,
        S_KDL_MUL,
        S_KDL_ADD,
        S_KDH_MUL,
        S_KDH_ADD,
        S_CTL,
        S_SIDE,
        S_SH_MUL,
        S_SH_CLAMP,
        S_SH_SLEW,
        S_EMIT
    } t_state;

    // saturate a wide signed value to a 16 bit speed
    function automatic logic signed [SPD_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32767);
        lo = -SAT_W'(32768);
        if (v > hi) begin
            return 16'sh7fff;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return v[SPD_W-1:0];
    endfunction

endpackage

/* hw/rtl/pdds_div.sv */
module pdds_div import pdds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DT_W-1:0]   i_divisor,
    output logic              o_busy,
    output logic [DIV_W-1:0]  o_quot
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [DT_W-1:0]      r_rem;
    logic [DT_W-1:0]      r_den;

    logic [DT_W+1:0]      trial;
    logic                 fits;
    logic [DT_W-1:0]      rem_next;

    // one restoring step: shift in next dividend bit, try the subtract
    always_comb begin
        trial    = {1'b0, r_rem, r_num[DIV_W-1]} - {2'b00, r_den};
        fits     = !trial[DT_W+1];
        rem_next = fits ? trial[DT_W-1:0] : {r_rem[DT_W-2:0], r_num[DIV_W-1]};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], fits};
            r_rem <= rem_next;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule

/* hw/rtl/pdds_mul.sv */
module pdds_mul import pdds_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_p
);

    logic signed [PROD_W-1:0] r_p;

    // shared signed multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

/* hw/rtl/pid_differential_drive_shaper.sv */
// Heading PID controller feeding a differential-drive shaper. Each input word
// (heading error Q4.12, time step Q0.16, zero taken as one LSB) updates a
// clamped integral, forms the derivative as error change over the step, and
// produces one output word of left and right drive in Q8.8 after speed cap,
// dead zone, scale/offset, output limit and slew limit. The derivative
// divide is a 32-step restoring divider started right after accept, and
// the gain products share one 24x17 multiplier that also serves the
// shaping of both sides. An output word that is not yet taken does not
// hold up the next item, which computes on and waits in its emit step
// until the output register is free.
// Configuration writes take effect at once and belong between items.
module pid_differential_drive_shaper import pdds_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [ERR_W-1:0] i_heading_error,
    input  logic [DT_W-1:0]         i_time_step,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [SPD_W-1:0] o_left_drive,
    output logic signed [SPD_W-1:0] o_right_drive
);

    // configuration registers
    logic signed [GAIN_W-1:0] r_prop_gain;
    logic signed [GAIN_W-1:0] r_integ_gain;
    logic signed [GAIN_W-1:0] r_deriv_gain;
    logic [LIM_W-1:0]         r_integ_lim;
    logic signed [SPD_W-1:0]  r_base_speed;
    logic signed [SPD_W-1:0]  r_speed_cap;
    logic [OLIM_W-1:0]        r_out_limit;
    logic [OLIM_W-1:0]        r_slew_limit;

    // sequencer and datapath registers
    t_state                   r_state;
    t_state                   n_state;
    logic signed [ERR_W-1:0]  r_e;
    logic [DT_W-1:0]          r_dt;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ISUM_W-1:0] r_isum;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [Q_W-1:0]    r_q;
    logic signed [CTL_W-1:0]  r_ctl;
    logic signed [SPD_W-1:0]  r_side_l;
    logic signed [SPD_W-1:0]  r_side_r;
    logic signed [SPD_W-1:0]  r_shaped;
    logic                     r_sel;
    logic signed [SPD_W-1:0]  r_prev_l;
    logic signed [SPD_W-1:0]  r_prev_r;
    logic signed [SPD_W-1:0]  r_out_l;
    logic signed [SPD_W-1:0]  r_out_r;
    logic                     r_out_valid;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      div_start;
    logic                      div_busy;
    logic [DIV_W-1:0]          div_quot;
    logic [DIFF_W-1:0]         diff_abs;
    logic [DIV_W-1:0]          div_num;

    // combinational datapath
    logic                      in_acc;
    logic                      slot_free;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [PROD_W-1:0]  prod_fl;
    logic signed [ACC_W-1:0]   prod_fl_ext;
    logic signed [ISUM_W-1:0]  lim_pos;
    logic signed [ISUM_W-1:0]  lim_neg;
    logic signed [ISUM_W-1:0]  integ_ext;
    logic signed [ISUM_W-1:0]  isum_clamp;
    logic signed [Q_W-1:0]     q_signed;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [ACC_W-1:0]   acc_sh;
    logic signed [SAT_W-1:0]   side_l_w;
    logic signed [SAT_W-1:0]   side_r_w;
    logic signed [SAT_W-1:0]   cap_w;
    logic signed [SPD_W-1:0]   side;
    logic signed [MUL_B_W-1:0] side_ext;
    logic signed [MUL_B_W-1:0] mag;
    logic                      dead;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [SHP_W-1:0]   shp_raw;
    logic signed [SHP_W-1:0]   shp_lim;
    logic signed [SHP_W-1:0]   shp_sgn;
    logic signed [SPD_W-1:0]   prev;
    logic signed [SLEW_W-1:0]  slew_d;
    logic signed [SLEW_W-1:0]  slew_lim;
    logic signed [SLEW_W-1:0]  slew_r;
    logic signed [SPD_W-1:0]   slewed;

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    pdds_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // derivative numerator magnitude scaled by 2^16
    assign diff_abs = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
    assign div_num  = {diff_abs[ERR_W-1:0], {(DIV_W-ERR_W){1'b0}}};

    pdds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (r_dt),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= RST_PROP_GAIN;
            r_integ_gain <= RST_INTEG_GAIN;
            r_deriv_gain <= RST_DERIV_GAIN;
            r_integ_lim  <= RST_INTEG_LIM;
            r_base_speed <= RST_BASE_SPEED;
            r_speed_cap  <= RST_SPEED_CAP;
            r_out_limit  <= RST_OUT_LIMIT;
            r_slew_limit <= RST_SLEW_LIMIT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_LIM:  r_integ_lim  <= i_cfg_data[LIM_W-1:0];
                CFG_BASE_SPEED: r_base_speed <= i_cfg_data[SPD_W-1:0];
                CFG_SPEED_CAP:  r_speed_cap  <= i_cfg_data[SPD_W-1:0];
                CFG_OUT_LIMIT:  r_out_limit  <= i_cfg_data[OLIM_W-1:0];
                CFG_SLEW_LIMIT: r_slew_limit <= i_cfg_data[OLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (in_acc) n_state = S_INT_MUL;
            S_INT_MUL:   n_state = S_INT_ADD;
            S_INT_ADD:   n_state = S_INT_CLAMP;
            S_INT_CLAMP: n_state = S_KP_MUL;
            S_KP_MUL:    n_state = S_KP_ADD;
            S_KP_ADD:    n_state = S_KIL_MUL;
            S_KIL_MUL:   n_state = S_KIL_ADD;
            S_KIL_ADD:   n_state = S_KIH_MUL;
            S_KIH_MUL:   n_state = S_KIH_ADD;
            S_KIH_ADD:   n_state = S_DIV_WAIT;
            S_DIV_WAIT:  if (!div_busy) n_state = S_KDL_MUL;
            S_KDL_MUL:   n_state = S_KDL_ADD;
            S_KDL_ADD:   n_state = S_KDH_MUL;
            S_KDH_MUL:   n_state = S_KDH_ADD;
            S_KDH_ADD:   n_state = S_CTL;
            S_CTL:       n_state = S_SIDE;
            S_SIDE:      n_state = S_SH_MUL;
            S_SH_MUL:    n_state = S_SH_CLAMP;
            S_SH_CLAMP:  n_state = S_SH_SLEW;
            S_SH_SLEW:   n_state = r_sel ? S_EMIT : S_SH_MUL;
            S_EMIT:      if (slot_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer outputs: multiplier operands, divider start, input ready
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_INT_MUL: begin
                mul_a     = {{(MUL_A_W-ERR_W){r_e[ERR_W-1]}}, r_e};
                mul_b     = {1'b0, r_dt};
                div_start = 1'b1;
            end
            S_KP_MUL: begin
                mul_a = r_prop_gain;
                mul_b = {r_e[ERR_W-1], r_e};
            end
            S_KIL_MUL: begin
                mul_a = r_integ_gain;
                mul_b = {1'b0, r_integ[15:0]};
            end
            S_KIH_MUL: begin
                mul_a = r_integ_gain;
                mul_b = {r_integ[INTEG_W-1], r_integ[INTEG_W-1:16]};
            end
            S_KDL_MUL: begin
                mul_a = r_deriv_gain;
                mul_b = {1'b0, r_q[15:0]};
            end
            S_KDH_MUL: begin
                mul_a = r_deriv_gain;
                mul_b = r_q[Q_W-1:16];
            end
            S_SH_MUL: begin
                mul_a = {{(MUL_A_W-16){1'b0}}, SCALE_A};
                mul_b = mag;
            end
            default: ;
        endcase
    end

    // product alignment for the accumulator
    always_comb begin
        prod_ext    = {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
        prod_fl     = mul_p >>> 16;
        prod_fl_ext = {{(ACC_W-PROD_W){prod_fl[PROD_W-1]}}, prod_fl};
    end

    // integral clamp and signed quotient
    always_comb begin
        lim_pos   = {2'b00, r_integ_lim};
        lim_neg   = -lim_pos;
        integ_ext = {r_integ[INTEG_W-1], r_integ};
        if (r_isum < lim_neg) begin
            isum_clamp = lim_neg;
        end else if (r_isum > lim_pos) begin
            isum_clamp = lim_pos;
        end else begin
            isum_clamp = r_isum;
        end
        q_signed = r_diff[DIFF_W-1] ? -{1'b0, div_quot} : {1'b0, div_quot};
    end

    // control rounding and side speeds
    always_comb begin
        acc_rnd  = r_acc + {{(ACC_W-CTL_SH){1'b0}}, 1'b1, {(CTL_SH-1){1'b0}}};
        acc_sh   = acc_rnd >>> CTL_SH;
        cap_w    = {{(SAT_W-SPD_W){r_speed_cap[SPD_W-1]}}, r_speed_cap};
        side_l_w = {{(SAT_W-SPD_W){r_base_speed[SPD_W-1]}}, r_base_speed}
                 - {{(SAT_W-CTL_W){r_ctl[CTL_W-1]}}, r_ctl};
        side_r_w = {{(SAT_W-SPD_W){r_base_speed[SPD_W-1]}}, r_base_speed}
                 + {{(SAT_W-CTL_W){r_ctl[CTL_W-1]}}, r_ctl};
        if (side_l_w > cap_w) side_l_w = cap_w;
        if (side_r_w > cap_w) side_r_w = cap_w;
    end

    // magnitude shaping of the selected side
    always_comb begin
        side     = r_sel ? r_side_r : r_side_l;
        side_ext = {side[SPD_W-1], side};
        mag      = side[SPD_W-1] ? -side_ext : side_ext;
        dead     = $unsigned(mag) < {1'b0, DEAD_ZONE};
        prod_rnd = (mul_p + PROD_W'(128)) >>> 8;
        if (dead) begin
            shp_raw = '0;
        end else begin
            shp_raw = prod_rnd[SHP_W-1:0] + {{(SHP_W-16){OFFSET_B[15]}}, OFFSET_B};
        end
        if (shp_raw > $signed({{(SHP_W-OLIM_W){1'b0}}, r_out_limit})) begin
            shp_lim = {{(SHP_W-OLIM_W){1'b0}}, r_out_limit};
        end else begin
            shp_lim = shp_raw;
        end
        shp_sgn = side[SPD_W-1] ? -shp_lim : shp_lim;
    end

    // slew limit against the previous drive of the selected side
    always_comb begin
        prev     = r_sel ? r_prev_r : r_prev_l;
        slew_lim = {3'b000, r_slew_limit};
        slew_d   = {{2{r_shaped[SPD_W-1]}}, r_shaped} - {{2{prev[SPD_W-1]}}, prev};
        if (slew_d > slew_lim) begin
            slew_r = {{2{prev[SPD_W-1]}}, prev} + slew_lim;
        end else if (slew_d < -slew_lim) begin
            slew_r = {{2{prev[SPD_W-1]}}, prev} - slew_lim;
        end else begin
            slew_r = {{2{r_shaped[SPD_W-1]}}, r_shaped};
        end
        slewed = sat16({{(SAT_W-SLEW_W){slew_r[SLEW_W-1]}}, slew_r});
    end

    // controller state that persists across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ    <= '0;
            r_prev_l   <= '0;
            r_prev_r   <= '0;
            r_sel      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_prev_err <= i_heading_error;
                r_sel      <= 1'b0;
            end
            if (r_state == S_INT_CLAMP) begin
                r_integ <= isum_clamp[INTEG_W-1:0];
            end
            if (r_state == S_SH_SLEW) begin
                if (r_sel) begin
                    r_prev_r <= slewed;
                end else begin
                    r_prev_l <= slewed;
                end
                r_sel <= !r_sel;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_e    <= i_heading_error;
                    r_dt   <= (i_time_step == '0) ? DT_W'(1) : i_time_step;
                    r_diff <= {i_heading_error[ERR_W-1], i_heading_error}
                            - {r_prev_err[ERR_W-1], r_prev_err};
                end
            end
            S_INT_ADD:  r_isum <= integ_ext + mul_p[ISUM_W-1:0];
            S_KP_MUL:   r_acc  <= '0;
            S_KP_ADD:   r_acc  <= r_acc + prod_ext;
            S_KIL_ADD:  r_acc  <= r_acc + prod_fl_ext;
            S_KIH_ADD:  r_acc  <= r_acc + prod_ext;
            S_DIV_WAIT: if (!div_busy) r_q <= q_signed;
            S_KDL_ADD:  r_acc  <= r_acc + prod_ext;
            S_KDH_ADD:  r_acc  <= r_acc + (prod_ext <<< 16);
            S_CTL:      r_ctl  <= acc_sh[CTL_W-1:0];
            S_SIDE: begin
                r_side_l <= sat16(side_l_w);
                r_side_r <= sat16(side_r_w);
            end
            S_SH_CLAMP: r_shaped <= sat16({{(SAT_W-SHP_W){shp_sgn[SHP_W-1]}}, shp_sgn});
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && slot_free) begin
            r_out_l <= r_prev_l;
            r_out_r <= r_prev_r;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_out_l;
    assign o_right_drive = r_out_r;

    // a new output word only appears out of the emit step
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("output word raised outside emit step");

    // derivative products only start once the divider has finished
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KDL_MUL) |-> $past(!div_busy))
        else $error("derivative multiply before divide finished");

    // integral stays inside the configured limit after clamping
    a_integ_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KP_MUL) |-> (integ_ext <= lim_pos && integ_ext >= lim_neg))
        else $error("integral outside limit");

    // a pending output word is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && o_out_valid && !i_out_ready) |=> (r_state == S_EMIT))
        else $error("emit left while output word pending");

endmodule
